// ----- rtl/tme_pkg.sv -----
// Shared types and constants of the tape machine execute unit.
`default_nettype none

package tme_pkg;

  localparam int OP_W    = 3;
  localparam int COUNT_W = 4;
  localparam int ADDR_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 15;

  // Instruction codes as they arrive on the command channel.
  localparam logic [OP_W-1:0] OP_LEFT   = 3'd0;
  localparam logic [OP_W-1:0] OP_RIGHT  = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd2;
  localparam logic [OP_W-1:0] OP_SUB    = 3'd3;
  localparam logic [OP_W-1:0] OP_OPEN   = 3'd4;
  localparam logic [OP_W-1:0] OP_CLOSE  = 3'd5;
  localparam logic [OP_W-1:0] OP_OUTPUT = 3'd6;
  localparam logic [OP_W-1:0] OP_INPUT  = 3'd7;

  // What happens to the current cell.
  localparam logic [1:0] CELL_KEEP = 2'd0;
  localparam logic [1:0] CELL_ADD  = 2'd1;
  localparam logic [1:0] CELL_SUB  = 2'd2;
  localparam logic [1:0] CELL_LOAD = 2'd3;

  // Branch condition.
  localparam logic [1:0] BR_NONE    = 2'd0;
  localparam logic [1:0] BR_ZERO    = 2'd1;
  localparam logic [1:0] BR_NONZERO = 2'd2;

  // Classified instruction handed from the front to the back.
  typedef struct packed {
    logic                move;         // head moves by a nonzero step
    logic                left;
    logic [COUNT_W-1:0]  step;
    logic [1:0]          cell_op;
    logic [1:0]          branch;
    logic                emit;
    logic [BYTE_W-1:0]   data;
    logic [ADDR_W-1:0]   seq_address;  // instruction address plus one
    logic [ADDR_W-1:0]   jump_address; // bracket address plus one
  } uop_t;

endpackage

`default_nettype wire

// ----- rtl/tme_if.sv -----
// Command and result channel interfaces of the tape machine execute unit.
`default_nettype none

interface tme_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [tme_pkg::OP_W-1:0]     operation;
  logic [tme_pkg::COUNT_W-1:0]  repeat_count;
  logic [tme_pkg::ADDR_W-1:0]   instr_address;
  logic [tme_pkg::ADDR_W-1:0]   match_address;
  logic [tme_pkg::BYTE_W-1:0]   in_byte;
  logic                         in_end;

  modport source (output valid, operation, repeat_count, instr_address, match_address,
                  in_byte, in_end, input ready);
  modport sink (input valid, operation, repeat_count, instr_address, match_address,
                in_byte, in_end, output ready);
endinterface

interface tme_res_if;
  logic                         valid;
  logic                         ready;
  logic [tme_pkg::ADDR_W-1:0]   next_address;
  logic                         branch_taken;
  logic                         out_valid;
  logic [tme_pkg::BYTE_W-1:0]   out_byte;
  logic [tme_pkg::BYTE_W-1:0]   cell_now;
  logic [tme_pkg::POS_W-1:0]    tape_position;

  modport source (output valid, next_address, branch_taken, out_valid, out_byte, cell_now,
                  tape_position, input ready);
  modport sink (input valid, next_address, branch_taken, out_valid, out_byte, cell_now,
                tape_position, output ready);
endinterface

`default_nettype wire

// ----- rtl/tme_front.sv -----
// Front end: accepts command words, classifies them and queues them for the back end.
`default_nettype none

module tme_front (
  input  wire logic     clk,
  input  wire logic     rst,
  tme_cmd_if.sink       cmd,
  input  wire logic     clearing,
  output tme_pkg::uop_t q_uop,
  output logic          q_valid,
  input  wire logic     q_pop
);
  import tme_pkg::*;

  uop_t       uop;
  uop_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       push;

  // Turn the raw instruction into the operations the back end performs.
  always_comb begin
    uop              = '0;
    uop.step         = cmd.repeat_count;
    uop.data         = cmd.in_byte;
    uop.seq_address  = cmd.instr_address + ADDR_W'(1);
    uop.jump_address = cmd.match_address + ADDR_W'(1);
    case (cmd.operation)
      OP_LEFT: begin
        uop.move = (cmd.repeat_count != '0);
        uop.left = 1'b1;
      end
      OP_RIGHT:  uop.move    = (cmd.repeat_count != '0);
      OP_ADD:    uop.cell_op = CELL_ADD;
      OP_SUB:    uop.cell_op = CELL_SUB;
      OP_OPEN:   uop.branch  = BR_ZERO;
      OP_CLOSE:  uop.branch  = BR_NONZERO;
      OP_OUTPUT: uop.emit    = 1'b1;
      OP_INPUT:  uop.cell_op = cmd.in_end ? CELL_KEEP : CELL_LOAD;
      default:   uop.cell_op = CELL_KEEP;
    endcase
  end

  // Two-entry queue; ready depends on the fill level and is held low while the tape is cleared.
  assign cmd.ready = !clearing && (count != 2'd2);
  assign push      = cmd.valid && cmd.ready;
  assign q_valid   = (count != 2'd0);
  assign q_uop     = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !q_pop) begin
      count_next = count + 2'd1;
    end else if (q_pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= uop;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tme_back.sv -----
// Back end: data pointer, tape memory with clearing sweep, cell update and result register.
`default_nettype none

module tme_back #(
  parameter int TAPE_CELLS = 32768
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire tme_pkg::uop_t q_uop,
  output logic               q_pop,
  output logic               clearing,
  tme_res_if.source          res
);
  import tme_pkg::*;

  localparam int HW = $clog2(TAPE_CELLS);
  localparam int PW = (HW > POS_W) ? HW : POS_W;
  localparam logic [HW:0]   CELLS_EXT = (HW+1)'(TAPE_CELLS);
  localparam logic [HW-1:0] LAST_CELL = HW'(TAPE_CELLS - 1);

  logic [BYTE_W-1:0] tape [TAPE_CELLS];
  logic [BYTE_W-1:0] rdata;

  logic [HW-1:0]     head;
  logic [HW-1:0]     head_new;
  logic [HW:0]       right_sum;
  logic [HW:0]       right_wrap;
  logic [HW:0]       left_wrap;
  logic [HW-1:0]     clr_addr;

  logic              b_valid;
  uop_t              b_uop;
  logic [HW-1:0]     b_head;
  logic              b_adv;
  logic              issue;

  logic [BYTE_W-1:0] cur_cell;
  logic [BYTE_W-1:0] cell_cur;
  logic [BYTE_W-1:0] cell_new;
  logic              taken;

  logic              we;
  logic [HW-1:0]     waddr;
  logic [BYTE_W-1:0] wdata;

  logic              o_valid;
  logic [ADDR_W-1:0] o_next_address;
  logic              o_taken;
  logic              o_emit;
  logic [BYTE_W-1:0] o_byte;
  logic [BYTE_W-1:0] o_cell;
  logic [PW-1:0]     o_head;

  // Pointer update at issue, modulo the tape size.
  always_comb begin
    right_sum  = {1'b0, head} + (HW+1)'(q_uop.step);
    right_wrap = (right_sum >= CELLS_EXT) ? right_sum - CELLS_EXT : right_sum;
    left_wrap  = {1'b0, head} + CELLS_EXT - (HW+1)'(q_uop.step);
    if (!q_uop.move) begin
      head_new = head;
    end else if (q_uop.left) begin
      head_new = ({1'b0, head} >= (HW+1)'(q_uop.step)) ? head - HW'(q_uop.step)
                                                        : left_wrap[HW-1:0];
    end else begin
      head_new = right_wrap[HW-1:0];
    end
  end

  assign b_adv = b_valid && (!o_valid || res.ready);
  assign issue = q_valid && !clearing && (!b_valid || b_adv);
  assign q_pop = issue;

  // After a move the cell comes from memory, otherwise from the forwarded register.
  always_comb begin
    cell_cur = b_uop.move ? rdata : cur_cell;
    case (b_uop.cell_op)
      CELL_ADD:  cell_new = cell_cur + BYTE_W'(b_uop.step);
      CELL_SUB:  cell_new = cell_cur - BYTE_W'(b_uop.step);
      CELL_LOAD: cell_new = b_uop.data;
      default:   cell_new = cell_cur;
    endcase
    case (b_uop.branch)
      BR_ZERO:    taken = (cell_cur == '0);
      BR_NONZERO: taken = (cell_cur != '0);
      default:    taken = 1'b0;
    endcase
  end

  assign we    = clearing || (b_adv && (b_uop.cell_op != CELL_KEEP));
  assign waddr = clearing ? clr_addr : b_head;
  assign wdata = clearing ? '0 : cell_new;

  always_ff @(posedge clk) begin
    if (we) begin
      tape[waddr] <= wdata;
    end
    if (issue && q_uop.move) begin
      rdata <= tape[head_new];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      head     <= '0;
      cur_cell <= '0;
      b_valid  <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + HW'(1);
        if (clr_addr == LAST_CELL) begin
          clearing <= 1'b0;
        end
      end
      if (issue) begin
        head    <= head_new;
        b_valid <= 1'b1;
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end
      if (b_adv) begin
        cur_cell <= cell_new;
        o_valid  <= 1'b1;
      end else if (res.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_uop  <= q_uop;
      b_head <= head_new;
    end
    if (b_adv) begin
      o_next_address <= taken ? b_uop.jump_address : b_uop.seq_address;
      o_taken        <= taken;
      o_emit         <= b_uop.emit;
      o_byte         <= b_uop.emit ? cell_cur : '0;
      o_cell         <= cell_new;
      o_head         <= PW'(b_head);
    end
  end

  assign res.valid         = o_valid;
  assign res.next_address  = o_next_address;
  assign res.branch_taken  = o_taken;
  assign res.out_valid     = o_emit;
  assign res.out_byte      = o_byte;
  assign res.cell_now      = o_cell;
  assign res.tape_position = o_head[POS_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/tape_machine_execute_unit.sv -----
// Top level of the tape machine execute unit.
`default_nettype none

// The unit executes one decoded tape machine instruction per word on the cmd channel
// and returns exactly one result word per instruction on the res channel, in order.
// It sustains one instruction per clock cycle while results are taken: the cell at
// the data pointer is forwarded in a register between back-to-back instructions, and
// after a pointer move the new cell is read from the single-port-read tape memory in
// the same cycle the instruction enters execution. A command word passes from the
// queue into execution and then into the result register, from which a ready
// receiver takes its result word. A two-entry queue decouples the command side from
// the result side, and the result register lets the unit keep taking words while a
// finished result waits. After reset the tape memory is cleared one cell per cycle,
// and cmd.ready stays low until the sweep is done. The data pointer wraps modulo
// TAPE_CELLS, cell arithmetic wraps at eight bits and the next program address wraps
// at sixteen bits. An input instruction with in_end set leaves the cell unchanged,
// and out_byte is zero unless out_valid is set.
module tape_machine_execute_unit #(
  parameter int TAPE_CELLS = 32768
) (
  input  wire logic clk,
  input  wire logic rst,
  tme_cmd_if.sink   cmd,
  tme_res_if.source res
);
  import tme_pkg::*;

  uop_t q_uop;
  logic q_valid;
  logic q_pop;
  logic clearing;

  // Classification and queue.
  tme_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .clearing (clearing),
    .q_uop    (q_uop),
    .q_valid  (q_valid),
    .q_pop    (q_pop)
  );

  // Pointer, tape memory, cell update and the result register.
  tme_back #(
    .TAPE_CELLS (TAPE_CELLS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_uop    (q_uop),
    .q_pop    (q_pop),
    .clearing (clearing),
    .res      (res)
  );

endmodule

`default_nettype wire

// ----- rtl/tme_checker.sv -----
// Port-level checks of the tape machine execute unit and their binding.
`default_nettype none

module tme_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        cmd_valid,
  input wire logic                        cmd_ready,
  input wire logic                        res_valid,
  input wire logic                        res_ready,
  input wire logic [tme_pkg::ADDR_W-1:0]  res_next_address,
  input wire logic [tme_pkg::BYTE_W-1:0]  res_cell_now,
  input wire logic [tme_pkg::POS_W-1:0]   res_tape_position
);
  import tme_pkg::*;

  logic [2:0] pending;

  // Words accepted whose results have not yet been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
    end else begin
      pending <= pending + 3'((cmd_valid && cmd_ready) ? 1 : 0)
                         - 3'((res_valid && res_ready) ? 1 : 0);
    end
  end

  a_clear_after_reset: assert property (@(posedge clk) $past(rst) |-> !cmd_ready)
    else $error("command accepted while the tape is being cleared");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> pending != 3'd0)
    else $error("result word without an outstanding command");

  a_bounded_pending: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd4)
    else $error("more words in flight than the unit can hold");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_next_address)
      && $stable(res_cell_now) && $stable(res_tape_position))
    else $error("stalled result word changed");

endmodule

bind tape_machine_execute_unit tme_checker u_checker (
  .clk               (clk),
  .rst               (rst),
  .cmd_valid         (cmd.valid),
  .cmd_ready         (cmd.ready),
  .res_valid         (res.valid),
  .res_ready         (res.ready),
  .res_next_address  (res.next_address),
  .res_cell_now      (res.cell_now),
  .res_tape_position (res.tape_position)
);

`default_nettype wire
